// File: src/ifrba_pkg.sv
// ----------------------------------------------------------------------------
// ifrba_pkg
// Shared types and constants for the IMU frame receiver with angle decode.
// ----------------------------------------------------------------------------
package ifrba_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [17:0] angle_type;
   typedef logic [1:0]  csr_index_type;

   // Configuration register indexes.
   localparam csr_index_type CsrSyncValue     = 2'd0;
   localparam csr_index_type CsrDeviceAddress = 2'd1;
   localparam csr_index_type CsrAngleCommand  = 2'd2;
   localparam csr_index_type CsrCleanCommand  = 2'd3;

   // Reset values of the configuration registers.
   localparam byte_type SyncValueReset     = 8'h68;
   localparam byte_type DeviceAddressReset = 8'h00;
   localparam byte_type AngleCommandReset  = 8'h84;
   localparam byte_type CleanCommandReset  = 8'h28;

   // Payload positions read back after a good frame.
   localparam int CommandPos  = 0;
   localparam int AngleHiPos  = 7;
   localparam int AngleMidPos = 8;
   localparam int AngleLoPos  = 9;

   // Decimal weights of the angle nibbles.
   localparam angle_type Weight10000 = 18'd10000;
   localparam angle_type Weight1000  = 18'd1000;
   localparam angle_type Weight100   = 18'd100;
   localparam angle_type Weight10    = 18'd10;

endpackage

// File: src/ifrba_payload_store.sv
// ----------------------------------------------------------------------------
// ifrba_payload_store
// Payload byte memory: one write port, two registered read ports. A valid bit
// per entry makes entries that were never written since reset read as zero.
// ----------------------------------------------------------------------------
module ifrba_payload_store #(
   parameter int DEPTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  ifrba_pkg::byte_type       wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr_b,
   output ifrba_pkg::byte_type       rd_data_a,
   output ifrba_pkg::byte_type       rd_data_b
);

   ifrba_pkg::byte_type store_ff [DEPTH];
   logic [DEPTH-1:0]    valid_ff;
   ifrba_pkg::byte_type rd_data_a_ff;
   ifrba_pkg::byte_type rd_data_b_ff;

   // Valid bits are cleared at reset and set on the first write of an entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Memory array and registered reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= valid_ff[rd_addr_a] ? store_ff[rd_addr_a] : '0;
      rd_data_b_ff <= valid_ff[rd_addr_b] ? store_ff[rd_addr_b] : '0;
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: src/imu_frame_receiver_bcd_angle_unit.sv
// ----------------------------------------------------------------------------
// imu_frame_receiver_bcd_angle_unit
// Serial frame parser: sync, length, address, payload, check byte. Good frames
// report the command byte, a held BCD-style angle and command flags.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req_rx_byte) takes one received
//   byte per cycle. Each byte advances the frame parser by one step.
//   The response channel (rsp_*) carries one item per frame whose check byte
//   matches the 8-bit sum of length, address and payload bytes; bad frames
//   produce nothing.
//   Payload bytes go into a synchronous memory. After a good check byte the
//   block reads back the command byte and payload byte 7, then bytes 8 and 9,
//   through the two read ports, decodes the angle, and registers the result:
//   the response is registered after the stage1 and stage2 read-back steps.
//   Throughput is one byte per cycle. Only the check byte can be held off: it
//   stalls while an earlier result is still being read back or still waits
//   in the output register for the receiver to take it.
//   Reset returns the parser to sync search, clears the configuration to its
//   defaults, the held angle to zero and marks all payload entries empty
//   (empty entries read as zero). The csr_* port writes one register per
//   cycle and should be used only while the block is idle.
// ----------------------------------------------------------------------------
module imu_frame_receiver_bcd_angle_unit #(
   parameter int PAYLOAD_DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  ifrba_pkg::byte_type            req_rx_byte,
   // Response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output ifrba_pkg::byte_type            rsp_command_code,
   output ifrba_pkg::angle_type           rsp_angle_hundredths,
   output logic                           rsp_angle_updated,
   output logic                           rsp_clean_ack,
   // Configuration port
   input  logic                           csr_write_enable,
   input  ifrba_pkg::csr_index_type       csr_index,
   input  ifrba_pkg::byte_type            csr_write_data
);

   localparam int AddrWidth = $clog2(PAYLOAD_DEPTH);

   // Parser phase codes.
   localparam logic [2:0] PhSync    = 3'd0;
   localparam logic [2:0] PhLen     = 3'd1;
   localparam logic [2:0] PhAddr    = 3'd2;
   localparam logic [2:0] PhPayload = 3'd3;
   localparam logic [2:0] PhCheck   = 3'd4;

   localparam logic [AddrWidth-1:0] AddrCommand  = AddrWidth'(ifrba_pkg::CommandPos);
   localparam logic [AddrWidth-1:0] AddrAngleHi  = AddrWidth'(ifrba_pkg::AngleHiPos);
   localparam logic [AddrWidth-1:0] AddrAngleMid = AddrWidth'(ifrba_pkg::AngleMidPos);
   localparam logic [AddrWidth-1:0] AddrAngleLo  = AddrWidth'(ifrba_pkg::AngleLoPos);

   // Configuration registers.
   ifrba_pkg::byte_type sync_value_ff;
   ifrba_pkg::byte_type device_address_ff;
   ifrba_pkg::byte_type angle_command_ff;
   ifrba_pkg::byte_type clean_command_ff;

   // Parser state.
   logic [2:0]          phase_ff,   phase_in;
   ifrba_pkg::byte_type sum_ff,     sum_in;
   ifrba_pkg::byte_type length_ff,  length_in;
   ifrba_pkg::byte_type count_ff,   count_in;

   // Read-back sequence and result.
   logic                 stage1_ff;
   logic                 stage2_ff;
   ifrba_pkg::byte_type  cmd_ff;
   ifrba_pkg::byte_type  angle_hi_ff;
   ifrba_pkg::angle_type held_angle_ff;
   logic                 rsp_valid_ff;
   ifrba_pkg::byte_type  rsp_command_ff;
   ifrba_pkg::angle_type rsp_angle_ff;
   logic                 rsp_updated_ff;
   logic                 rsp_clean_ff;

   logic                 accept;
   logic                 good_check;
   logic                 wr_en;
   ifrba_pkg::byte_type  need;
   ifrba_pkg::byte_type  count_next;
   logic [AddrWidth-1:0] rd_addr_a;
   logic [AddrWidth-1:0] rd_addr_b;
   ifrba_pkg::byte_type  rd_data_a;
   ifrba_pkg::byte_type  rd_data_b;
   ifrba_pkg::angle_type decoded_angle;
   ifrba_pkg::angle_type new_angle;
   logic                 cmd_is_angle;

   // The check byte waits while an earlier result is in flight or not taken.
   assign req_stall = (phase_ff == PhCheck) && (rsp_valid_ff || stage1_ff || stage2_ff);
   assign accept    = req_valid && !req_stall;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_value_ff     <= ifrba_pkg::SyncValueReset;
         device_address_ff <= ifrba_pkg::DeviceAddressReset;
         angle_command_ff  <= ifrba_pkg::AngleCommandReset;
         clean_command_ff  <= ifrba_pkg::CleanCommandReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ifrba_pkg::CsrSyncValue:     sync_value_ff     <= csr_write_data;
            ifrba_pkg::CsrDeviceAddress: device_address_ff <= csr_write_data;
            ifrba_pkg::CsrAngleCommand:  angle_command_ff  <= csr_write_data;
            ifrba_pkg::CsrCleanCommand:  clean_command_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Payload bytes needed: length minus three, at least one.
   assign need       = (length_ff > 8'd3) ? (length_ff - 8'd3) : 8'd1;
   assign count_next = count_ff + 8'd1;

   // Parser next state.
   always_comb begin
      phase_in   = phase_ff;
      sum_in     = sum_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      good_check = 1'b0;
      wr_en      = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PhSync: begin
               if (req_rx_byte == sync_value_ff) begin
                  phase_in = PhLen;
                  sum_in   = '0;
                  count_in = '0;
               end
            end
            PhLen: begin
               sum_in    = sum_ff + req_rx_byte;
               length_in = req_rx_byte;
               phase_in  = PhAddr;
            end
            PhAddr: begin
               if (req_rx_byte == device_address_ff) begin
                  sum_in   = sum_ff + req_rx_byte;
                  phase_in = PhPayload;
               end else begin
                  sum_in   = '0;
                  phase_in = PhSync;
               end
            end
            PhPayload: begin
               sum_in   = sum_ff + req_rx_byte;
               wr_en    = ({1'b0, count_ff} < 9'(PAYLOAD_DEPTH));
               count_in = count_next;
               if (count_next >= need) begin
                  phase_in = PhCheck;
               end
            end
            PhCheck: begin
               good_check = (req_rx_byte == sum_ff);
               sum_in     = '0;
               phase_in   = PhSync;
            end
            default: begin
               phase_in = PhSync;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PhSync;
         sum_ff    <= '0;
         length_ff <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         sum_ff    <= sum_in;
         length_ff <= length_in;
         count_ff  <= count_in;
      end
   end

   // Read back command and high angle byte first, then the two low bytes.
   assign rd_addr_a = stage1_ff ? AddrAngleMid : AddrCommand;
   assign rd_addr_b = stage1_ff ? AddrAngleLo  : AddrAngleHi;

   ifrba_payload_store #(
      .DEPTH (PAYLOAD_DEPTH)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (count_ff[AddrWidth-1:0]),
      .wr_data   (req_rx_byte),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Sequence flags for the read-back: stage1 and stage2.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
      end else begin
         stage1_ff <= good_check;
         stage2_ff <= stage1_ff;
      end
   end

   // First read pair arrives in the cycle after the check byte, while stage1 is set.
   always_ff @(posedge clock) begin
      if (stage1_ff) begin
         cmd_ff      <= rd_data_a;
         angle_hi_ff <= rd_data_b;
      end
   end

   // Nibble decode into hundredths of a degree; the sign nibble is ignored.
   assign decoded_angle = 18'(angle_hi_ff[3:0]) * ifrba_pkg::Weight10000
                        + 18'(rd_data_a[7:4])   * ifrba_pkg::Weight1000
                        + 18'(rd_data_a[3:0])   * ifrba_pkg::Weight100
                        + 18'(rd_data_b[7:4])   * ifrba_pkg::Weight10
                        + 18'(rd_data_b[3:0]);
   assign cmd_is_angle  = (cmd_ff == angle_command_ff);
   assign new_angle     = cmd_is_angle ? decoded_angle : held_angle_ff;

   // Held angle.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_angle_ff <= '0;
      end else if (stage2_ff) begin
         held_angle_ff <= new_angle;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage2_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage2_ff) begin
         rsp_command_ff <= cmd_ff;
         rsp_angle_ff   <= new_angle;
         rsp_updated_ff <= cmd_is_angle;
         rsp_clean_ff   <= (cmd_ff == clean_command_ff);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_command_code     = rsp_command_ff;
   assign rsp_angle_hundredths = rsp_angle_ff;
   assign rsp_angle_updated    = rsp_updated_ff;
   assign rsp_clean_ack        = rsp_clean_ff;

endmodule
